>>> sv/first_fit_segment_allocator_defines.svh
// Assertion macros for the first-fit segment allocator.
// Depends on nothing; the asserting module provides clk and arst_n.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
// Implication checked in the same cycle.
`define FFSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication checked in the following cycle.
`define FFSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> sv/ffsa_pkg.sv
// Shared types and constants of the first-fit segment allocator.
// Depends on nothing.
package ffsa_pkg;
	localparam int MaxSegmentsDef = 16;
	localparam int QueueDepthDef = 8;
	localparam logic [15:0] TotalSizeReset = 16'd1000;

	typedef enum logic [1:0] {
		KIND_PLACED = 2'd0,
		KIND_QUEUED = 2'd1,
		KIND_REJECTED = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		SEG_NOP,
		SEG_LOAD,
		SEG_FREE,
		SEG_MERGE,
		SEG_PLACE
	} seg_op_t;

	typedef enum logic [1:0] {
		Q_NOP,
		Q_CLEAR,
		Q_PUSH,
		Q_POP_AT
	} q_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RELEASE,
		ST_MERGE,
		ST_QSCAN,
		ST_PLACE,
		ST_DONE
	} state_t;

	typedef struct packed {
		seg_op_t op;
		logic [15:0] size;
		logic [7:0] owner;
		logic [15:0] release_time;
		logic [15:0] total;
	} seg_cmd_t;

	typedef struct packed {
		q_op_t op;
		logic [7:0] id;
		logic [15:0] size;
		logic [15:0] hold;
	} q_cmd_t;
endpackage

>>> sv/ffsa_seg_table.sv
// Ordered segment table with load, insert, merge and free operations.
// Depends on ffsa_pkg.
module ffsa_seg_table #(
	parameter int MAX_SEGMENTS = 16
) (
	input logic clk,
	input logic arst_n,
	input ffsa_pkg::seg_cmd_t cmd,
	input logic [$clog2(MAX_SEGMENTS)-1:0] idx,
	output logic [15:0] rd_base,
	output logic [15:0] rd_len,
	output logic [15:0] rd_release,
	output logic [MAX_SEGMENTS-1:0] busy_vec,
	output logic [$clog2(MAX_SEGMENTS+1)-1:0] count
);
	import ffsa_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	logic [15:0] base_q [MAX_SEGMENTS];
	logic [15:0] len_q [MAX_SEGMENTS];
	logic [7:0] owner_q [MAX_SEGMENTS];
	logic [15:0] rel_q [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] busy_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_n;
	logic split;

	assign idx_n = idx + 1'b1;
	assign split = len_q[idx] != cmd.size;
	assign rd_base = base_q[idx];
	assign rd_len = len_q[idx];
	assign rd_release = rel_q[idx];
	assign busy_vec = busy_q;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			busy_q <= '0;
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				base_q[i] <= '0;
				len_q[i] <= '0;
			end
			len_q[0] <= TotalSizeReset;
		end else begin
			unique case (cmd.op)
				SEG_LOAD: begin
					count_q <= CW'(1);
					busy_q <= '0;
					base_q[0] <= '0;
					len_q[0] <= cmd.total;
				end
				SEG_FREE: begin
					busy_q[idx] <= 1'b0;
				end
				SEG_MERGE: begin
					for (int k = 0; k < MAX_SEGMENTS - 1; k++) begin
						if (k > int'(idx)) begin
							base_q[k] <= base_q[k+1];
							len_q[k] <= len_q[k+1];
							busy_q[k] <= busy_q[k+1];
						end
					end
					len_q[idx] <= len_q[idx] + len_q[idx_n];
					count_q <= count_q - 1'b1;
				end
				SEG_PLACE: begin
					if (split) begin
						for (int k = 1; k < MAX_SEGMENTS; k++) begin
							if (k > int'(idx) + 1) begin
								base_q[k] <= base_q[k-1];
								len_q[k] <= len_q[k-1];
								busy_q[k] <= busy_q[k-1];
							end
						end
						base_q[idx_n] <= base_q[idx] + cmd.size;
						len_q[idx_n] <= len_q[idx] - cmd.size;
						busy_q[idx_n] <= 1'b0;
						count_q <= count_q + 1'b1;
					end
					len_q[idx] <= cmd.size;
					busy_q[idx] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			SEG_MERGE: begin
				for (int k = 0; k < MAX_SEGMENTS - 1; k++) begin
					if (k > int'(idx)) begin
						owner_q[k] <= owner_q[k+1];
						rel_q[k] <= rel_q[k+1];
					end
				end
			end
			SEG_PLACE: begin
				if (split) begin
					for (int k = 1; k < MAX_SEGMENTS; k++) begin
						if (k > int'(idx) + 1) begin
							owner_q[k] <= owner_q[k-1];
							rel_q[k] <= rel_q[k-1];
						end
					end
				end
				owner_q[idx] <= cmd.owner;
				rel_q[idx] <= cmd.release_time;
			end
			default: begin
			end
		endcase
	end
endmodule

>>> sv/ffsa_wait_queue.sv
// Wait queue of pending requests with removal at any position.
// Depends on ffsa_pkg.
module ffsa_wait_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	input ffsa_pkg::q_cmd_t cmd,
	input logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] idx,
	output logic [7:0] rd_id,
	output logic [15:0] rd_size,
	output logic [15:0] rd_hold,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
	import ffsa_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	logic [7:0] id_q [QUEUE_DEPTH];
	logic [15:0] size_q [QUEUE_DEPTH];
	logic [15:0] hold_q [QUEUE_DEPTH];
	logic [QCW-1:0] count_q;
	logic [QW-1:0] tail;

	assign tail = count_q[QW-1:0];
	assign rd_id = id_q[idx];
	assign rd_size = size_q[idx];
	assign rd_hold = hold_q[idx];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.op)
				Q_CLEAR: count_q <= '0;
				Q_PUSH: count_q <= count_q + 1'b1;
				Q_POP_AT: count_q <= count_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			Q_PUSH: begin
				id_q[tail] <= cmd.id;
				size_q[tail] <= cmd.size;
				hold_q[tail] <= cmd.hold;
			end
			Q_POP_AT: begin
				for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
					if (k >= int'(idx)) begin
						id_q[k] <= id_q[k+1];
						size_q[k] <= size_q[k+1];
						hold_q[k] <= hold_q[k+1];
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> sv/first_fit_segment_allocator.sv
// A time step is accepted when start is high and busy is low; busy then stays high while one
// sequencer releases, merges and places, visiting one table entry per cycle and making one
// placement attempt per waiting request plus the arrival. Each result is shown for one cycle
// with result_valid; the receiver cannot stall, and the last result of a step (step done)
// has last set.
`include "first_fit_segment_allocator_defines.svh"
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDef,
	parameter int QUEUE_DEPTH = ffsa_pkg::QueueDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic arrival_valid,
	input logic [7:0] req_id,
	input logic [15:0] req_size,
	input logic [15:0] hold_ticks,
	output logic result_valid,
	output logic [1:0] kind,
	output logic [7:0] owner_id,
	output logic [15:0] base_address,
	output logic [3:0] waiting_count,
	output logic last,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ffsa_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;
	logic [CW-1:0] j_q;
	logic [QCW-1:0] x_q;
	logic [7:0] cur_id_q, arr_id_q;
	logic [15:0] cur_size_q, cur_hold_q, arr_size_q, arr_hold_q;
	logic from_q_q, arr_valid_q;
	logic [15:0] now_q, total_q;
	logic cfg_wr, accept;
	seg_cmd_t seg_cmd;
	q_cmd_t q_cmd;
	logic [15:0] rd_base, rd_len, rd_release;
	logic [MAX_SEGMENTS-1:0] busy_vec;
	logic [CW-1:0] seg_count;
	logic [7:0] q_id;
	logic [15:0] q_size, q_hold;
	logic [QCW-1:0] wc;
	logic [IW-1:0] jidx;
	logic j_in, mrg_ok, both_free, x_in, fits;
	logic emit, emit_last;
	kind_t emit_kind;
	logic [7:0] emit_id;
	logic [15:0] emit_base;
	logic [QCW-1:0] emit_wc;

	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign accept = start && !busy;
	assign busy = state_q != ST_IDLE;
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {16'd0, total_q} : 32'd0;
	assign jidx = j_q[IW-1:0];

	assign j_in = j_q < seg_count;
	assign mrg_ok = ({1'b0, j_q} + 1'b1) < {1'b0, seg_count};
	assign both_free = !busy_vec[jidx] && !busy_vec[IW'(jidx + 1'b1)];
	assign x_in = x_q < wc;
	assign fits = !busy_vec[jidx] && (rd_len >= cur_size_q)
		&& !((rd_len != cur_size_q) && (seg_count == CW'(MAX_SEGMENTS)));

	ffsa_seg_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_seg (
		.clk(clk), .arst_n(arst_n), .cmd(seg_cmd), .idx(jidx),
		.rd_base(rd_base), .rd_len(rd_len),
		.rd_release(rd_release), .busy_vec(busy_vec), .count(seg_count)
	);

	ffsa_wait_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .cmd(q_cmd), .idx(x_q[QW-1:0]),
		.rd_id(q_id), .rd_size(q_size), .rd_hold(q_hold), .count(wc)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_RELEASE;
			ST_RELEASE: if (!j_in) state_d = ST_MERGE;
			ST_MERGE: if (!mrg_ok) state_d = ST_QSCAN;
			ST_QSCAN: state_d = (x_in || arr_valid_q) ? ST_PLACE : ST_DONE;
			ST_PLACE: begin
				if (!j_in || fits) state_d = from_q_q ? ST_QSCAN : ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		seg_cmd = '{op: SEG_NOP, size: cur_size_q, owner: cur_id_q,
			release_time: now_q + cur_hold_q, total: pwdata[15:0]};
		q_cmd = '{op: Q_NOP, id: cur_id_q, size: cur_size_q, hold: cur_hold_q};
		emit = 1'b0;
		emit_last = 1'b0;
		emit_kind = KIND_PLACED;
		emit_id = cur_id_q;
		emit_base = '0;
		emit_wc = wc;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_wr) begin
					seg_cmd.op = SEG_LOAD;
					q_cmd.op = Q_CLEAR;
				end
			end
			ST_RELEASE: begin
				if (j_in && busy_vec[jidx] && rd_release == now_q) seg_cmd.op = SEG_FREE;
			end
			ST_MERGE: begin
				if (mrg_ok && both_free) seg_cmd.op = SEG_MERGE;
			end
			ST_PLACE: begin
				if (j_in) begin
					if (fits) begin
						seg_cmd.op = SEG_PLACE;
						emit = 1'b1;
						emit_base = rd_base;
						if (from_q_q) begin
							q_cmd.op = Q_POP_AT;
							emit_wc = wc - 1'b1;
						end
					end
				end else if (!from_q_q) begin
					emit = 1'b1;
					if (wc < QCW'(QUEUE_DEPTH)) begin
						q_cmd.op = Q_PUSH;
						emit_kind = KIND_QUEUED;
						emit_wc = wc + 1'b1;
					end else begin
						emit_kind = KIND_REJECTED;
					end
				end
			end
			ST_DONE: begin
				emit = 1'b1;
				emit_last = 1'b1;
				emit_kind = KIND_DONE;
				emit_id = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			total_q <= TotalSizeReset;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= emit;
			if (cfg_wr && state_q == ST_IDLE) total_q <= pwdata[15:0];
			if (state_q == ST_DONE) now_q <= now_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		kind <= emit_kind;
		owner_id <= emit_id;
		base_address <= emit_base;
		waiting_count <= 4'(emit_wc);
		last <= emit_last;
		unique case (state_q)
			ST_IDLE: begin
				j_q <= '0;
				if (accept) begin
					arr_valid_q <= arrival_valid;
					arr_id_q <= req_id;
					arr_size_q <= req_size;
					arr_hold_q <= hold_ticks;
				end
			end
			ST_RELEASE: j_q <= j_in ? j_q + 1'b1 : '0;
			ST_MERGE: begin
				if (mrg_ok) begin
					if (!both_free) j_q <= j_q + 1'b1;
				end else begin
					x_q <= '0;
				end
			end
			ST_QSCAN: begin
				j_q <= '0;
				if (x_in) begin
					cur_id_q <= q_id;
					cur_size_q <= q_size;
					cur_hold_q <= q_hold;
					from_q_q <= 1'b1;
				end else begin
					cur_id_q <= arr_id_q;
					cur_size_q <= arr_size_q;
					cur_hold_q <= arr_hold_q;
					from_q_q <= 1'b0;
				end
			end
			ST_PLACE: begin
				if (j_in) begin
					if (!fits) j_q <= j_q + 1'b1;
				end else if (from_q_q) begin
					x_q <= x_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	`FFSA_ASSERT_IMP(a_last_on_done, result_valid, last == (kind == KIND_DONE),
		"last must mark exactly the step-done result")
	`FFSA_ASSERT_IMP(a_seg_count_range, 1'b1,
		seg_count != '0 && seg_count <= CW'(MAX_SEGMENTS), "segment count out of range")
	`FFSA_ASSERT_NXT(a_busy_after_accept, accept, busy, "busy must rise after a transfer")
	`FFSA_ASSERT_IMP(a_result_in_step, result_valid && kind != KIND_DONE, busy,
		"placement result outside a step")
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for first_fit_segment_allocator: directed and random time steps,
// with every result compared against an internal first-fit allocation predictor.
// Depends on ffsa_pkg and the first_fit_segment_allocator RTL.
`timescale 1ns / 100ps
module tb_top;
	import ffsa_pkg::*;

	localparam int NSEG = 16;
	localparam int QDEPTH = 8;
	localparam int STALL_LIMIT = 6000;

	typedef struct {
		kind_t kind;
		logic [7:0] owner;
		logic [15:0] base;
		logic [3:0] waiting;
		logic fin;
	} alloc_result_t;

	logic clk, arst_n, start, busy, arrival_valid;
	logic [7:0] req_id;
	logic [15:0] req_size, hold_ticks;
	logic result_valid, last, psel, penable, pwrite, pready;
	logic [1:0] kind;
	logic [7:0] owner_id;
	logic [15:0] base_address;
	logic [3:0] waiting_count;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	first_fit_segment_allocator DUT (.*);

	// Predictor state.
	logic [15:0] mem_size;
	logic [15:0] seg_start[NSEG];
	logic [15:0] seg_len[NSEG];
	logic [7:0] seg_id[NSEG];
	bit seg_taken[NSEG];
	logic [15:0] seg_free_at[NSEG];
	int seg_total;
	logic [7:0] q_id[QDEPTH];
	logic [15:0] q_size[QDEPTH];
	logic [15:0] q_hold[QDEPTH];
	int q_len;
	logic [15:0] step_time;

	alloc_result_t pending_results[$];
	int mismatches, steps_sent, results_seen, sender_idle_pct, stall_cycles;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic void reload_memory();
		for (int i = 0; i < NSEG; i++) begin
			seg_start[i] = 0;
			seg_len[i] = 0;
			seg_id[i] = 0;
			seg_taken[i] = 0;
			seg_free_at[i] = 0;
		end
		seg_len[0] = mem_size;
		seg_total = 1;
		q_len = 0;
	endfunction

	function automatic void shift_up(int from, int to);
		for (int k = to; k > from; k--) begin
			seg_start[k] = seg_start[k-1];
			seg_len[k] = seg_len[k-1];
			seg_id[k] = seg_id[k-1];
			seg_taken[k] = seg_taken[k-1];
			seg_free_at[k] = seg_free_at[k-1];
		end
	endfunction

	function automatic int first_fit(logic [7:0] id, logic [15:0] sz, logic [15:0] hd);
		bit split;
		for (int j = 0; j < seg_total; j++) begin
			if (seg_taken[j] || seg_len[j] < sz) continue;
			split = seg_len[j] != sz;
			if (split && seg_total >= NSEG) continue;
			if (split) begin
				shift_up(j + 1, seg_total);
				seg_start[j+1] = seg_start[j] + sz;
				seg_len[j+1] = seg_len[j] - sz;
				seg_id[j+1] = 0;
				seg_taken[j+1] = 0;
				seg_free_at[j+1] = 0;
				seg_total++;
			end
			seg_len[j] = sz;
			seg_id[j] = id;
			seg_taken[j] = 1;
			seg_free_at[j] = step_time + hd;
			return int'(seg_start[j]);
		end
		return -1;
	endfunction

	function automatic void push_result(kind_t k, logic [7:0] id, logic [15:0] b, logic f);
		alloc_result_t r;
		r.kind = k;
		r.owner = id;
		r.base = b;
		r.waiting = q_len[3:0];
		r.fin = f;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void predict_step(logic v, logic [7:0] id, logic [15:0] sz,
			logic [15:0] hd);
		int j, x, b;
		logic [7:0] pid;
		for (j = 0; j < seg_total; j++)
			if (seg_taken[j] && seg_free_at[j] == step_time) seg_taken[j] = 0;
		j = 0;
		while (j + 1 < seg_total) begin
			if (!seg_taken[j] && !seg_taken[j+1]) begin
				seg_len[j] = seg_len[j] + seg_len[j+1];
				for (int k = j + 1; k + 1 < seg_total; k++) begin
					seg_start[k] = seg_start[k+1];
					seg_len[k] = seg_len[k+1];
					seg_id[k] = seg_id[k+1];
					seg_taken[k] = seg_taken[k+1];
					seg_free_at[k] = seg_free_at[k+1];
				end
				seg_total--;
			end else begin
				j++;
			end
		end
		x = 0;
		while (x < q_len) begin
			b = first_fit(q_id[x], q_size[x], q_hold[x]);
			if (b >= 0) begin
				pid = q_id[x];
				for (int k = x; k + 1 < q_len; k++) begin
					q_id[k] = q_id[k+1];
					q_size[k] = q_size[k+1];
					q_hold[k] = q_hold[k+1];
				end
				q_len--;
				push_result(KIND_PLACED, pid, b[15:0], 0);
			end else begin
				x++;
			end
		end
		if (v) begin
			b = first_fit(id, sz, hd);
			if (b >= 0) begin
				push_result(KIND_PLACED, id, b[15:0], 0);
			end else if (q_len < QDEPTH) begin
				q_id[q_len] = id;
				q_size[q_len] = sz;
				q_hold[q_len] = hd;
				q_len++;
				push_result(KIND_QUEUED, id, 0, 0);
			end else begin
				push_result(KIND_REJECTED, id, 0, 0);
			end
		end
		push_result(KIND_DONE, 0, 0, 1);
		step_time = step_time + 1;
	endfunction

	task automatic send_step(logic v, logic [7:0] id, logic [15:0] sz, logic [15:0] hd);
		if ($urandom_range(99) < sender_idle_pct)
			repeat ($urandom_range(1, 6)) @(posedge clk);
		@(posedge clk);
		start <= 1;
		arrival_valid <= v;
		req_id <= id;
		req_size <= sz;
		hold_ticks <= hd;
		do @(posedge clk); while (busy);
		predict_step(v, id, sz, hd);
		steps_sent++;
		start <= 0;
	endtask

	task automatic wait_idle();
		while (pending_results.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		wait_idle();
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == 3'd0) begin
			mem_size = data[15:0];
			reload_memory();
		end
		@(posedge clk);
		psel <= 1;
		paddr <= 3'd0;
		@(posedge clk);
		penable <= 1;
		@(negedge clk);
		if (prdata[15:0] !== mem_size) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Register read mismatch: expected %0d, actual %0d", mem_size,
					prdata[15:0]);
		end
		@(posedge clk);
		psel <= 0;
		penable <= 0;
	endtask

	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && result_valid) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transfer: kind %0d owner %0d", kind, owner_id);
			end else begin
				e = pending_results.pop_front();
				if (e.kind !== kind || e.owner !== owner_id || e.base !== base_address ||
						e.waiting !== waiting_count || e.fin !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected k%0d o%0d b%0d w%0d l%0d, %s",
							e.kind, e.owner, e.base, e.waiting, e.fin,
							$sformatf("actual k%0d o%0d b%0d w%0d l%0d", kind, owner_id,
							base_address, waiting_count, last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy) || psel) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", pending_results.size());
			$display("first_fit_segment_allocator verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic test_field_extremes();
		send_step(0, 8'd0, 16'd0, 16'd0);
		send_step(1, 8'd255, 16'd1, 16'd1);
		send_step(1, 8'd0, 16'd65535, 16'd65535);
		send_step(1, 8'd170, 16'd999, 16'd2);
		send_step(1, 8'd85, 16'd1, 16'd0);
		send_step(1, 8'd7, 16'd0, 16'd3);
		send_step(0, 8'd255, 16'd65535, 16'd65535);
		send_step(1, 8'd9, 16'd500, 16'd1);
	endtask

	task automatic test_full_table_and_queue();
		apb_write(3'd0, 32'd20);
		for (int i = 0; i < 16; i++) send_step(1, 8'(i + 1), 16'd1, 16'd1000);
		send_step(1, 8'd40, 16'd5, 16'd1000);
		for (int i = 0; i < 9; i++) send_step(1, 8'(100 + i), 16'd3, 16'd4);
		apb_write(3'd4, 32'hFFFF_FFFF);
		send_step(1, 8'd200, 16'd1, 16'd5);
	endtask

	task automatic test_random(int n, logic [15:0] sz_cfg, int idle);
		logic [15:0] sz, hd, span;
		apb_write(3'd0, {16'hA5A5, sz_cfg});
		sender_idle_pct = idle;
		span = (sz_cfg / 6 == 0) ? 16'd1 : sz_cfg / 6;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: sz = 16'($urandom_range(0, 65535));
				1, 2: sz = 16'($urandom_range(1, sz_cfg));
				default: sz = 16'($urandom_range(1, span));
			endcase
			case ($urandom_range(9))
				0: hd = 16'($urandom_range(0, 65535));
				1, 2: hd = 16'($urandom_range(1, 200));
				default: hd = 16'($urandom_range(1, 12));
			endcase
			send_step($urandom_range(99) < 85, 8'($urandom_range(0, 255)), sz, hd);
		end
	endtask

	initial begin
		start <= 0;
		arrival_valid <= 0;
		req_id <= 0;
		req_size <= 0;
		hold_ticks <= 0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= 0;
		pwdata <= 0;
		mismatches = 0;
		steps_sent = 0;
		results_seen = 0;
		sender_idle_pct = 15;
		mem_size = TotalSizeReset;
		step_time = 0;
		reload_memory();
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		test_field_extremes();
		test_full_table_and_queue();
		test_random(90, 16'd1000, 15);
		test_random(90, 16'd64, 15);
		test_random(65, 16'd65535, 69);
		test_random(30, 16'd1, 69);
		test_random(70, 16'd300, 0);
		wait_idle();
		$display("Ran %0d time steps and checked %0d result transfers", steps_sent,
			results_seen);
		$display("Covered memory sizes 1 to 65535, a full segment table and a full queue");
		if (mismatches == 0) begin
			$display("first_fit_segment_allocator verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("first_fit_segment_allocator verification failed");
		end
		$finish;
	end
endmodule
